FILE: src/upc_pkg.sv
`timescale 1ns / 1ps
package upc_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_ENCODE_MODE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_SEPS   = 8'd1;

    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_0       = 8'h30;
    localparam logic [7:0] CHR_LA      = 8'h61;
    localparam logic [7:0] CHR_UA      = 8'h41;
    localparam logic [4:0] HEX_BAD     = 5'd16;
    localparam logic [3:0] TEN         = 4'd10;

    localparam logic [7:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic encode_mode;
        logic keep_seps;
    } t_cfg;

    typedef struct packed {
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
        logic [1:0] count;
        logic       text_end;
        logic       malformed;
    } t_job;

    function automatic logic is_unreserved(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
               b == 8'h2E || b == 8'h21 || b == 8'h7E || b == 8'h2A ||
               b == 8'h27 || b == 8'h28 || b == 8'h29;
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        return b == 8'h3B || b == 8'h2F || b == 8'h3F || b == 8'h3A ||
               b == 8'h40 || b == 8'h26 || b == 8'h3D || b == 8'h2B ||
               b == 8'h24 || b == 8'h2C || b == 8'h23;
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - CHR_0;
            return {1'b0, d[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            d = b - CHR_LA;
            return {1'b0, d[3:0] + TEN};
        end
        if (b >= 8'h41 && b <= 8'h46) begin
            d = b - CHR_UA;
            return {1'b0, d[3:0] + TEN};
        end
        return HEX_BAD;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_UPPER[nib];
    endfunction

endpackage

FILE: src/upc_front.sv
`timescale 1ns / 1ps
module upc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upc_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_push,
    output upc_pkg::t_job o_job
);
    import upc_pkg::*;

    t_phase     r_phase, n_phase, w_phase_step;
    logic [7:0] r_first, n_first, w_first_step;
    logic       r_err, n_err, w_err_step;
    logic [4:0] w_hi, w_lo;
    logic [7:0] w_val;
    logic       w_bad;

    assign w_hi  = hex_value(r_first);
    assign w_lo  = hex_value(i_byte);
    assign w_val = {w_hi[3:0], w_lo[3:0]};

    always_comb begin
        w_phase_step = r_phase;
        w_first_step = r_first;
        w_err_step   = r_err;
        if (!i_cfg.encode_mode && !r_err) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte == CHR_PERCENT) w_phase_step = PH_PCT;
                end
                PH_PCT: begin
                    if (w_lo[4]) begin
                        w_err_step = 1'b1;
                    end else begin
                        w_first_step = i_byte;
                        w_phase_step = PH_DIGIT;
                    end
                end
                PH_DIGIT: begin
                    if (w_hi[4] || w_lo[4]) w_err_step = 1'b1;
                    else w_phase_step = PH_IDLE;
                end
                default: w_phase_step = PH_IDLE;
            endcase
        end
        if (i_last) begin
            n_phase = PH_IDLE;
            n_first = 8'h00;
            n_err   = 1'b0;
        end else begin
            n_phase = w_phase_step;
            n_first = w_first_step;
            n_err   = w_err_step;
        end
    end

    always_comb begin
        o_job = '0;
        w_bad = !i_cfg.encode_mode && (w_err_step || w_phase_step != PH_IDLE);
        if (i_cfg.encode_mode) begin
            if (is_unreserved(i_byte) || (i_cfg.keep_seps && is_separator(i_byte))) begin
                o_job.count = 2'd1;
                o_job.b0    = i_byte;
            end else begin
                o_job.count = 2'd3;
                o_job.b0    = CHR_PERCENT;
                o_job.b1    = hex_char(i_byte[7:4]);
                o_job.b2    = hex_char(i_byte[3:0]);
            end
        end else if (!r_err) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte != CHR_PERCENT) begin
                        o_job.count = 2'd1;
                        o_job.b0    = i_byte;
                    end
                end
                PH_DIGIT: begin
                    if (!w_hi[4] && !w_lo[4]) begin
                        if (i_cfg.keep_seps && is_separator(w_val)) begin
                            o_job.count = 2'd3;
                            o_job.b0    = CHR_PERCENT;
                            o_job.b1    = r_first;
                            o_job.b2    = i_byte;
                        end else begin
                            o_job.count = 2'd1;
                            o_job.b0    = w_val;
                        end
                    end
                end
                default: o_job.count = 2'd0;
            endcase
        end
        if (i_last) begin
            o_job.text_end = 1'b1;
            if (w_bad) begin
                o_job.count     = 2'd1;
                o_job.b0        = 8'h00;
                o_job.malformed = 1'b1;
            end
        end
        o_push = i_accept && (o_job.count != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= 8'h00;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_err   <= n_err;
        end
    end

endmodule

FILE: src/upc_queue.sv
`timescale 1ns / 1ps
module upc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upc_pkg::t_job i_job,
    input  logic          i_pop,
    output upc_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import upc_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr_en, w_rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_job   = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr  = w_wr_en ? ((r_wr == LAST_SLOT) ? '0 : r_wr + PW'(1)) : r_wr;
        n_rd  = w_rd_en ? ((r_rd == LAST_SLOT) ? '0 : r_rd + PW'(1)) : r_rd;
        n_cnt = r_cnt;
        if (w_wr_en && !w_rd_en) n_cnt = r_cnt + CW'(1);
        else if (!w_wr_en && w_rd_en) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/upc_back.sv
`timescale 1ns / 1ps
module upc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upc_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_run_last,
    output logic          o_text_end,
    output logic          o_malformed
);
    import upc_pkg::*;

    t_job       r_job;
    logic       r_busy, n_busy;
    logic [1:0] r_pos, n_pos;
    logic       w_fire, w_final;

    assign o_valid = r_busy;
    assign w_fire  = r_busy && i_ready;
    assign w_final = (r_pos == r_job.count - 2'd1);
    assign o_pop   = !i_empty && (!r_busy || (w_fire && w_final));

    always_comb begin
        unique case (r_pos)
            2'd1:    o_byte = r_job.b1;
            2'd2:    o_byte = r_job.b2;
            default: o_byte = r_job.b0;
        endcase
        o_run_last  = w_final;
        o_text_end  = w_final && r_job.text_end;
        o_malformed = w_final && r_job.malformed;
    end

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (o_pop) begin
            n_busy = 1'b1;
            n_pos  = 2'd0;
        end else if (w_fire) begin
            if (w_final) n_busy = 1'b0;
            else n_pos = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

endmodule

FILE: src/uri_percent_codec.sv
`timescale 1ns / 1ps
// The first result byte is written to the job queue, then registered in the
// output stage, and is valid from there.
// Throughput: one result byte per cycle while m_axis_tready is high; an input
// byte yields 0, 1 or 3 result bytes. Input is taken every cycle while the
// QUEUE_DEPTH-entry job queue has room.
// Reset: synchronous; clears config (encode on, separators escaped), escape state,
// queue and output control.
module uri_percent_codec #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [upc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [upc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // in_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // out_byte
    output logic                            m_axis_tlast,
    output logic [1:0]                      m_axis_tuser   // text_end, malformed
);
    import upc_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job, w_pop_job;
    logic w_push, w_pop, w_empty, w_full, w_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.encode_mode <= 1'b1;
            r_cfg.keep_seps   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_ENCODE_MODE) r_cfg.encode_mode <= i_cfg_data[0];
            if (i_cfg_index == REG_KEEP_SEPS) r_cfg.keep_seps <= i_cfg_data[0];
        end
    end

    upc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    upc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    upc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_pop_job),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_run_last  (m_axis_tlast),
        .o_text_end  (m_axis_tuser[0]),
        .o_malformed (m_axis_tuser[1])
    );

    a_malformed_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tuser[0]
            && m_axis_tdata == 8'h00)
        else $error("malformed result not a lone zero end-of-text byte");

    a_text_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("text end without run last");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_empty && w_full))
        else $error("job queue both empty and full");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

endmodule
